FILE: design/jfhp_pkg.sv
package jfhp_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] CODE_SOI    = 8'hD8;
    localparam logic [7:0] CODE_EOI    = 8'hD9;
    localparam logic [7:0] CODE_SOF0   = 8'hC0;
    localparam logic [7:0] CODE_SOF2   = 8'hC2;
    localparam logic [7:0] PRECISION   = 8'd8;

    localparam logic [7:0] SF_1X1 = 8'h11;
    localparam logic [7:0] SF_2X1 = 8'h21;
    localparam logic [7:0] SF_1X2 = 8'h12;
    localparam logic [7:0] SF_2X2 = 8'h22;

    localparam logic [2:0] CLS_444  = 3'd0;
    localparam logic [2:0] CLS_422H = 3'd1;
    localparam logic [2:0] CLS_422V = 3'd2;
    localparam logic [2:0] CLS_420  = 3'd3;
    localparam logic [2:0] CLS_GRAY = 3'd4;
    localparam logic [2:0] CLS_NONE = 3'd5;

    typedef enum logic [8:0] {
        PH_START0 = 9'b000000001,
        PH_START1 = 9'b000000010,
        PH_MARK0  = 9'b000000100,
        PH_MARK1  = 9'b000001000,
        PH_LEN0   = 9'b000010000,
        PH_LEN1   = 9'b000100000,
        PH_SKIP   = 9'b001000000,
        PH_SOF    = 9'b010000000,
        PH_DONE   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic        ok;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  components;
        logic [2:0]  sampling_class;
        logic        progressive;
    } t_result;

    localparam t_result RESULT_FAIL = '{
        ok: 1'b0, height: 16'd0, width: 16'd0, components: 8'd0,
        sampling_class: CLS_NONE, progressive: 1'b0
    };

    function automatic logic [2:0] classify(
        input logic [7:0] count,
        input logic [7:0] sf0,
        input logic [7:0] sf1,
        input logic [7:0] sf2
    );
        logic [2:0] cls;
        cls = CLS_NONE;
        if (count == 8'd3) begin
            if (sf1 == SF_1X1 && sf2 == SF_1X1) begin
                case (sf0)
                    SF_1X1:  cls = CLS_444;
                    SF_2X1:  cls = CLS_422H;
                    SF_1X2:  cls = CLS_422V;
                    SF_2X2:  cls = CLS_420;
                    default: cls = CLS_NONE;
                endcase
            end
        end else if (count == 8'd1 && sf0 == SF_1X1) begin
            cls = CLS_GRAY;
        end
        return cls;
    endfunction

endpackage

FILE: design/jfhp_core.sv
module jfhp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_res_valid,
    output jfhp_pkg::t_result    o_res
);

    jfhp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_seg_len, n_seg_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_height, n_height;
    logic [15:0] r_width, n_width;
    logic [7:0]  r_ncomp, n_ncomp;
    logic [7:0]  r_sf0, n_sf0;
    logic [7:0]  r_sf1, n_sf1;
    logic [7:0]  r_sf2, n_sf2;

    logic        fail;
    logic        done;
    logic [16:0] idx_p1;
    logic [16:0] need;
    logic [2:0]  cls;

    always_comb begin
        n_phase     = r_phase;
        n_seg_len   = r_seg_len;
        n_count     = r_count;
        n_marker    = r_marker;
        n_height    = r_height;
        n_width     = r_width;
        n_ncomp     = r_ncomp;
        n_sf0       = r_sf0;
        n_sf1       = r_sf1;
        n_sf2       = r_sf2;
        fail        = 1'b0;
        done        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = jfhp_pkg::RESULT_FAIL;
        idx_p1      = {1'b0, r_count} + 17'd1;
        need        = (r_ncomp == 8'd3) ? 17'd17 : 17'd11;
        cls         = jfhp_pkg::CLS_NONE;

        case (r_phase)
            jfhp_pkg::PH_START0: begin
                if (i_data_byte != jfhp_pkg::MARK_PREFIX) fail = 1'b1;
                else n_phase = jfhp_pkg::PH_START1;
            end
            jfhp_pkg::PH_START1: begin
                if (i_data_byte != jfhp_pkg::CODE_SOI) fail = 1'b1;
                else n_phase = jfhp_pkg::PH_MARK0;
            end
            jfhp_pkg::PH_MARK0: begin
                if (i_data_byte != jfhp_pkg::MARK_PREFIX) fail = 1'b1;
                else n_phase = jfhp_pkg::PH_MARK1;
            end
            jfhp_pkg::PH_MARK1: begin
                if (i_data_byte == jfhp_pkg::CODE_SOI || i_data_byte == jfhp_pkg::CODE_EOI) begin
                    n_phase = jfhp_pkg::PH_MARK0;
                end else begin
                    n_marker = i_data_byte;
                    n_phase  = jfhp_pkg::PH_LEN0;
                end
            end
            jfhp_pkg::PH_LEN0: begin
                n_seg_len = {i_data_byte, 8'h00};
                n_count   = 16'd1;
                n_phase   = jfhp_pkg::PH_LEN1;
            end
            jfhp_pkg::PH_LEN1: begin
                n_seg_len = {r_seg_len[15:8], i_data_byte};
                n_count   = 16'd2;
                if (r_marker == jfhp_pkg::CODE_SOF0 || r_marker == jfhp_pkg::CODE_SOF2) begin
                    n_phase = jfhp_pkg::PH_SOF;
                end else if (n_seg_len < 16'd2) begin
                    fail = 1'b1;
                end else if (n_seg_len == 16'd2) begin
                    n_phase = jfhp_pkg::PH_MARK0;
                end else begin
                    n_phase = jfhp_pkg::PH_SKIP;
                end
            end
            jfhp_pkg::PH_SKIP: begin
                n_count = r_count + 16'd1;
                if (n_count >= r_seg_len) n_phase = jfhp_pkg::PH_MARK0;
            end
            jfhp_pkg::PH_SOF: begin
                if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
                case (r_count)
                    16'd2: begin
                        if (i_data_byte != jfhp_pkg::PRECISION) fail = 1'b1;
                    end
                    16'd3: n_height = {i_data_byte, 8'h00};
                    16'd4: n_height = {r_height[15:8], i_data_byte};
                    16'd5: n_width = {i_data_byte, 8'h00};
                    16'd6: begin
                        n_width = {r_width[15:8], i_data_byte};
                        if (r_height == 16'd0 || n_width == 16'd0) fail = 1'b1;
                    end
                    16'd7: begin
                        n_ncomp = i_data_byte;
                        if (i_data_byte != 8'd1 && i_data_byte != 8'd3) fail = 1'b1;
                    end
                    16'd9:  n_sf0 = i_data_byte;
                    16'd12: if (r_ncomp == 8'd3) n_sf1 = i_data_byte;
                    16'd15: if (r_ncomp == 8'd3) n_sf2 = i_data_byte;
                    default: ;
                endcase
                if (r_count >= 16'd8 && idx_p1 >= {1'b0, r_seg_len} && idx_p1 >= need) begin
                    cls = jfhp_pkg::classify(r_ncomp, n_sf0, n_sf1, n_sf2);
                    if (cls == jfhp_pkg::CLS_NONE) fail = 1'b1;
                    else done = 1'b1;
                end
            end
            default: ;
        endcase

        if (fail) begin
            o_res_valid = 1'b1;
            n_phase     = jfhp_pkg::PH_DONE;
        end else if (done) begin
            o_res_valid          = 1'b1;
            o_res.ok             = 1'b1;
            o_res.height         = r_height;
            o_res.width          = r_width;
            o_res.components     = r_ncomp;
            o_res.sampling_class = cls;
            o_res.progressive    = (r_marker == jfhp_pkg::CODE_SOF2);
            n_phase              = jfhp_pkg::PH_DONE;
        end

        if (i_last_byte) begin
            if (!o_res_valid && r_phase != jfhp_pkg::PH_DONE) begin
                o_res_valid = 1'b1;
                o_res       = jfhp_pkg::RESULT_FAIL;
            end
            n_phase   = jfhp_pkg::PH_START0;
            n_seg_len = 16'd0;
            n_count   = 16'd0;
            n_marker  = 8'd0;
            n_height  = 16'd0;
            n_width   = 16'd0;
            n_ncomp   = 8'd0;
            n_sf0     = 8'd0;
            n_sf1     = 8'd0;
            n_sf2     = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jfhp_pkg::PH_START0;
            r_seg_len <= 16'd0;
            r_count   <= 16'd0;
            r_marker  <= 8'd0;
            r_height  <= 16'd0;
            r_width   <= 16'd0;
            r_ncomp   <= 8'd0;
            r_sf0     <= 8'd0;
            r_sf1     <= 8'd0;
            r_sf2     <= 8'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_seg_len <= n_seg_len;
            r_count   <= n_count;
            r_marker  <= n_marker;
            r_height  <= n_height;
            r_width   <= n_width;
            r_ncomp   <= n_ncomp;
            r_sf0     <= n_sf0;
            r_sf1     <= n_sf1;
            r_sf2     <= n_sf2;
        end
    end

endmodule

FILE: design/jpeg_frame_header_parser_unit.sv
// Frame header parser for a JPEG byte stream.
// The input channel carries one file byte per request on i_data_byte, with
// i_last_byte set on the final byte of each file; a request is taken at a
// clock edge where i_valid is high and o_stall is low.
// The output channel gives exactly one result per file on o_ok, o_height,
// o_width, o_components, o_sampling_class and o_progressive; it is taken at
// an edge where o_valid is high and i_stall is low.
// Each byte is handled in the cycle it is accepted; the result it decides is
// registered in the output register, or in the skid register if one is held.
// One byte is accepted per cycle for as long as o_stall is low.
// When the receiver stalls, a held result stays on the outputs and bytes keep
// being accepted; a second result is kept in a one-entry skid register, and
// o_stall is high while that register is full, until the held result is taken.
// A synchronous reset returns the parser to the start of a file and
// empties both result registers. The parser state also returns to the start
// of a file after every byte marked last.
module jpeg_frame_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [15:0] o_height,
    output logic [15:0] o_width,
    output logic [7:0]  o_components,
    output logic [2:0]  o_sampling_class,
    output logic        o_progressive
);

    logic              take;
    logic              res_valid;
    logic              pop;
    jfhp_pkg::t_result res;
    logic              r_out_valid;
    jfhp_pkg::t_result r_out;
    logic              r_skid_valid;
    jfhp_pkg::t_result r_skid;

    assign o_stall = r_skid_valid;
    assign take    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && !i_stall;

    jfhp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= take && res_valid;
        end else if (take && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || pop) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_height         = r_out.height;
    assign o_width          = r_out.width;
    assign o_components     = r_out.components;
    assign o_sampling_class = r_out.sampling_class;
    assign o_progressive    = r_out.progressive;

endmodule

FILE: design/jfhp_checker.sv
module jfhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_ok,
    input logic [15:0] o_height,
    input logic [15:0] o_width,
    input logic [7:0]  o_components,
    input logic [2:0]  o_sampling_class,
    input logic        o_progressive
);

    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte) && $stable(i_last_byte))
        else $error("Input request changed while stalled.");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result request dropped while stalled.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_ok) && $stable(o_height) && $stable(o_width)
            && $stable(o_components) && $stable(o_sampling_class) && $stable(o_progressive))
        else $error("Result payload changed while stalled.");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_height == 16'd0 && o_width == 16'd0
            && o_components == 8'd0 && o_sampling_class == jfhp_pkg::CLS_NONE
            && !o_progressive)
        else $error("Failure result carries nonzero fields.");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> o_height != 16'd0 && o_width != 16'd0
            && (o_components == 8'd1 || o_components == 8'd3)
            && o_sampling_class != jfhp_pkg::CLS_NONE
            && (o_components == 8'd3 || o_sampling_class == jfhp_pkg::CLS_GRAY))
        else $error("Success result with inconsistent fields.");

endmodule

bind jpeg_frame_header_parser_unit jfhp_checker u_jfhp_checker (.*);
